/* design/sfrm_pkg.sv */
// ----------------------------------------------------------------------------
// sfrm_pkg
// Shared types and constants for the square frame rotate/mirror block.
// ----------------------------------------------------------------------------
package sfrm_pkg;

  localparam int SideDefault = 64;
  localparam int CoordW      = 6;
  localparam int PixelW      = 8;
  localparam int CmdW        = 3;

  localparam logic [PixelW-1:0] BlankCode = 8'h20;

  typedef enum logic [CmdW-1:0] {
    CMD_WRITE    = 3'd0,
    CMD_READ     = 3'd1,
    CMD_ROTATE   = 3'd2,
    CMD_MIRROR_H = 3'd3,
    CMD_MIRROR_V = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_XFORM,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [PixelW-1:0] pixel;
    logic [CmdW-1:0]   cmd;
  } result_t;

endpackage

/* design/sfrm_frame_mem.sv */
// ----------------------------------------------------------------------------
// sfrm_frame_mem
// Two-bank frame memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sfrm_frame_mem import sfrm_pkg::*; #(
  parameter int AddrW = 13
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AddrW-1:0]  waddr,
  input  logic [PixelW-1:0] wdata,
  input  logic [AddrW-1:0]  raddr,
  output logic [PixelW-1:0] rdata
);

  localparam int Depth = 2 ** AddrW;

  logic [PixelW-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* design/sfrm_ctrl.sv */
// ----------------------------------------------------------------------------
// sfrm_ctrl
// Command sequencer: clearing pass, cell access and whole-frame transforms.
// ----------------------------------------------------------------------------
module sfrm_ctrl import sfrm_pkg::*; #(
  parameter int SIDE  = SideDefault,
  parameter int IdxW  = $clog2(SIDE),
  parameter int AddrW = 2 * IdxW + 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              ready,
  input  logic [CmdW-1:0]   command,
  input  logic [CoordW-1:0] row,
  input  logic [CoordW-1:0] col,
  input  logic [PixelW-1:0] pixel_in,
  output logic              res_valid,
  input  logic              res_take,
  output result_t           res,
  output logic              mem_we,
  output logic [AddrW-1:0]  mem_waddr,
  output logic [PixelW-1:0] mem_wdata,
  output logic [AddrW-1:0]  mem_raddr,
  input  logic [PixelW-1:0] mem_rdata
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(SIDE - 1);

  state_t            state, state_next;
  logic              bank;
  logic [IdxW-1:0]   r_cnt, c_cnt;
  logic              xf_pend;
  logic [AddrW-1:0]  xf_waddr;
  logic [CmdW-1:0]   cmd_q;
  logic              rd_inside;

  logic              walk_last;
  logic              in_inside;
  logic [IdxW-1:0]   row_idx, col_idx;
  logic [IdxW-1:0]   nr, nc;

  assign walk_last = (r_cnt == LastIdx) && (c_cnt == LastIdx);
  assign in_inside = (32'(row) < 32'(SIDE)) && (32'(col) < 32'(SIDE));
  assign row_idx   = IdxW'(row);
  assign col_idx   = IdxW'(col);
  assign ready     = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);

  // destination cell of the transform walk
  always_comb begin
    unique case (cmd_q)
      CMD_ROTATE: begin
        nr = c_cnt;
        nc = LastIdx - r_cnt;
      end
      CMD_MIRROR_H: begin
        nr = r_cnt;
        nc = LastIdx - c_cnt;
      end
      default: begin
        nr = LastIdx - r_cnt;
        nc = c_cnt;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    mem_we     = xf_pend;
    mem_waddr  = xf_waddr;
    mem_wdata  = mem_rdata;
    mem_raddr  = {bank, r_cnt, c_cnt};
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = {1'b0, r_cnt, c_cnt};
        mem_wdata = BlankCode;
        if (walk_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          unique case (command)
            CMD_WRITE: begin
              mem_we     = in_inside;
              mem_waddr  = {bank, row_idx, col_idx};
              mem_wdata  = pixel_in;
              state_next = ST_DONE;
            end
            CMD_READ: begin
              mem_raddr  = {bank, row_idx, col_idx};
              state_next = ST_READ;
            end
            CMD_ROTATE, CMD_MIRROR_H, CMD_MIRROR_V: begin
              state_next = ST_XFORM;
            end
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_READ:  state_next = ST_DONE;
      ST_XFORM: begin
        if (walk_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_DONE;
      ST_DONE: begin
        if (res_take) state_next = ST_IDLE;
      end
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      bank    <= 1'b0;
      r_cnt   <= '0;
      c_cnt   <= '0;
      xf_pend <= 1'b0;
    end else begin
      state   <= state_next;
      xf_pend <= (state == ST_XFORM);
      // advance the row-major walk; wrap to the origin at the end
      if (state == ST_CLEAR || state == ST_XFORM) begin
        if (c_cnt == LastIdx) begin
          c_cnt <= '0;
          r_cnt <= (r_cnt == LastIdx) ? '0 : r_cnt + 1'b1;
        end else begin
          c_cnt <= c_cnt + 1'b1;
        end
      end
      if (state == ST_DRAIN) bank <= ~bank;
    end
  end

  always_ff @(posedge clk) begin
    xf_waddr <= {~bank, nr, nc};
    if (state == ST_IDLE && in_valid) begin
      cmd_q     <= command;
      rd_inside <= in_inside;
      res.pixel <= '0;
      res.cmd   <= command;
    end
    if (state == ST_READ) begin
      res.pixel <= rd_inside ? mem_rdata : '0;
    end
  end

endmodule

/* design/square_frame_rotate_mirror.sv */
// ----------------------------------------------------------------------------
// square_frame_rotate_mirror
// Square frame of SIDE x SIDE 8-bit cells with cell access, clockwise
// rotation and horizontal/vertical mirroring, held in a two-bank memory.
// ----------------------------------------------------------------------------
// Throughput: one item at a time; the next item is taken once the result of
//   the current one has moved into the output register. Transforms are set by
//   the single memory read port: one cell per cycle.
// Reset: clears control state, selects bank 0, then sweeps bank 0 to the
//   blank code cell by cell with in_stall high.
module square_frame_rotate_mirror import sfrm_pkg::*; #(
  parameter int SIDE = SideDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CmdW-1:0]   command,
  input  logic [CoordW-1:0] row,
  input  logic [CoordW-1:0] col,
  input  logic [PixelW-1:0] pixel_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [PixelW-1:0] pixel_out,
  output logic [CmdW-1:0]   done_command
);

  // Cell address is {bank, row, col}; non-power-of-two sides leave holes.
  localparam int IdxW  = $clog2(SIDE);
  localparam int AddrW = 2 * IdxW + 1;

  logic              ready;
  logic              res_valid;
  logic              res_take;
  result_t           res;
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic [PixelW-1:0] mem_wdata;
  logic [AddrW-1:0]  mem_raddr;
  logic [PixelW-1:0] mem_rdata;

  // Stall input whenever the sequencer is busy (clearing, reading,
  // transforming or holding a finished result).
  assign in_stall = ~ready;

  // Output slot is free when empty or being drained this cycle.
  assign res_take = ~out_valid | ~out_stall;

  sfrm_ctrl #(
    .SIDE  (SIDE),
    .IdxW  (IdxW),
    .AddrW (AddrW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .ready     (ready),
    .command   (command),
    .row       (row),
    .col       (col),
    .pixel_in  (pixel_in),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  sfrm_frame_mem #(
    .AddrW (AddrW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register: load a finished item when the slot is free, drop the
  // shown item once taken, hold it while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      pixel_out    <= res.pixel;
      done_command <= res.cmd;
    end
  end

endmodule

/* design/sfrm_checker.sv */
// ----------------------------------------------------------------------------
// sfrm_checker
// Port-level checks for the square frame block, bound to the top level.
// ----------------------------------------------------------------------------
module sfrm_checker import sfrm_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [PixelW-1:0] pixel_out,
  input logic [CmdW-1:0]   done_command
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pixel_out) && $stable(done_command))
    else $error("stalled result changed");

  // reset starts the clearing pass, so no item is taken right after it
  a_clear_stall: assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("item accepted during clearing pass");

  // one item at a time: an accepted item blocks the input next cycle
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item accepted while one is in flight");

  // only reads carry a cell value
  a_zero_pixel: assert property (@(posedge clk) disable iff (rst)
    out_valid && (done_command != CMD_READ) |-> pixel_out == '0)
    else $error("non-read result with nonzero pixel");

endmodule

bind square_frame_rotate_mirror sfrm_checker u_sfrm_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .pixel_out    (pixel_out),
  .done_command (done_command)
);
